// ===== hdl/pva_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package pva_pkg;
    localparam int DEF_NUM_VOICES = 32;
    localparam int DEF_TIME_BITS  = 48;

    typedef enum logic [2:0] {
        ACT_ALLOC     = 3'd0,
        ACT_RELEASE   = 3'd1,
        ACT_STOP_ALL  = 3'd2,
        ACT_STOP_ROLE = 3'd3,
        ACT_UPDATE    = 3'd4
    } t_action;

    localparam logic [1:0] MODE_IDLE      = 2'd0;
    localparam logic [1:0] MODE_ACTIVE    = 2'd1;
    localparam logic [1:0] MODE_RELEASING = 2'd2;

    localparam logic [1:0] POL_OLDEST   = 2'd0;
    localparam logic [1:0] POL_PRIORITY = 2'd1;
    localparam logic [1:0] POL_QUIETEST = 2'd2;

    localparam logic [7:0] REG_STEAL_ENABLE = 8'd0;
    localparam logic [7:0] REG_STEAL_POLICY = 8'd1;

    localparam logic [1:0] PRIO_RESET = 2'd3;
endpackage
`default_nettype wire

// ===== hdl/pva_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module pva_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end
endmodule
`default_nettype wire

// ===== hdl/poly_voice_allocator_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// each action runs a table scan that reads one slot per cycle: allocate, stop all, stop
// role and time update scan every slot, release only its target slot, unused actions none
// flow: one item at a time, the next accepted the cycle after the result is
// registered; a held result stalls the input
// reset: synchronous active low; per-slot valid bits make every slot read as idle
// with priority 3 and zeroed fields, steal_enable 1, steal_policy 1, no clearing pass
module poly_voice_allocator_top
    import pva_pkg::*;
#(
    parameter int NUM_VOICES = DEF_NUM_VOICES,
    parameter int TIME_BITS  = DEF_TIME_BITS
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    // note_pitch, note_velocity, note_priority, voice_role, event_time,
    // duration_samples, target_voice
    input  wire logic [111:0] i_s_axis_tdata,
    // action
    input  wire logic [2:0]   i_s_axis_tuser,
    output logic              o_m_axis_tvalid,
    input  wire logic         i_m_axis_tready,
    // voice_slot, granted, was_stolen, sounding_count, free_count
    output logic [23:0]       o_m_axis_tdata,
    input  wire logic         i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire logic [7:0]   i_cfg_addr,
    input  wire logic [7:0]   i_cfg_data
);
    localparam int AW = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
    localparam int CW = $clog2(NUM_VOICES + 1);
    localparam int TB = TIME_BITS;

    typedef struct packed {
        logic [1:0]    mode;
        logic [1:0]    prio;
        logic [6:0]    pitch;
        logic [6:0]    vel;
        logic [3:0]    role;
        logic [TB-1:0] start;
        logic [TB-1:0] stop;
    } t_voice;

    localparam int EW = $bits(t_voice);

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_WRITE, S_FIN} t_state;

    t_state         r_state;
    logic [2:0]     r_act;
    logic [6:0]     r_pitch, r_vel;
    logic [1:0]     r_prio;
    logic [3:0]     r_role;
    logic [TB-1:0]  r_now, r_stop_new;
    logic [AW-1:0]  r_cnt, r_last, r_didx;
    logic           r_iss_done, r_dv, r_ent_vld;
    logic [NUM_VOICES-1:0] r_vld;
    logic [CW-1:0]  r_idle_cnt;
    logic           r_steal_en;
    logic [1:0]     r_policy;
    logic           r_fnd_idle, r_have_vic;
    logic [AW-1:0]  r_idle_slot, r_vic;
    logic [1:0]     r_vic_prio;
    logic [6:0]     r_vic_vel;
    logic [TB-1:0]  r_vic_start;
    logic [4:0]     r_slot_out;
    logic           r_granted, r_stolen;
    logic           r_m_valid;
    logic [23:0]    r_m_data;

    logic [63:0]    ev64;
    logic [TB-1:0]  now_in;
    logic [64:0]    sum;
    logic           ovf;
    logic [8:0]     target9;
    logic           accept;
    t_voice         rd_raw, ent, wr_ent, new_ent;
    logic           wr_en;
    logic [AW-1:0]  wr_addr;
    logic           sounding, better, retire;
    logic [CW-1:0]  sound_cnt;

    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready     = 1'b1;
    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_m_data;

    assign ev64    = {16'b0, i_s_axis_tdata[67:20]};
    assign now_in  = ev64[TB-1:0];
    assign sum     = 65'(now_in) + 65'(i_s_axis_tdata[99:68]);
    assign ovf     = |(sum >> TB);
    assign target9 = {4'b0, i_s_axis_tdata[104:100]};

    pva_ram #(.WIDTH(EW), .DEPTH(NUM_VOICES)) u_ram (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en),
        .i_wr_addr(wr_addr),
        .i_wr_data(wr_ent),
        .i_rd_addr(r_cnt),
        .o_rd_data(rd_raw)
    );

    always_comb begin
        if (r_ent_vld) begin
            ent = rd_raw;
        end else begin
            ent       = '0;
            ent.mode  = MODE_IDLE;
            ent.prio  = PRIO_RESET;
        end
        sounding = (ent.mode == MODE_ACTIVE) || (ent.mode == MODE_RELEASING);
        case (r_policy)
            POL_PRIORITY: better = ent.prio > r_vic_prio;
            POL_QUIETEST: better = ent.vel < r_vic_vel;
            default:      better = ent.start < r_vic_start;
        endcase
        new_ent.mode  = MODE_ACTIVE;
        new_ent.prio  = r_prio;
        new_ent.pitch = r_pitch;
        new_ent.vel   = r_vel;
        new_ent.role  = r_role;
        new_ent.start = r_now;
        new_ent.stop  = r_stop_new;

        wr_en   = 1'b0;
        wr_addr = r_didx;
        wr_ent  = ent;
        retire  = 1'b0;
        if (r_state == S_SCAN && r_dv) begin
            case (r_act)
                ACT_RELEASE: begin
                    if (ent.mode == MODE_ACTIVE) begin
                        wr_en       = 1'b1;
                        wr_ent.mode = MODE_RELEASING;
                        wr_ent.stop = r_now;
                    end
                end
                ACT_STOP_ALL: begin
                    if (sounding) begin
                        retire       = 1'b1;
                        wr_ent.mode  = MODE_IDLE;
                        wr_ent.pitch = '0;
                        wr_ent.vel   = '0;
                        wr_ent.start = '0;
                        wr_ent.stop  = '0;
                    end
                end
                ACT_STOP_ROLE: begin
                    retire      = sounding && (ent.role == r_role);
                    wr_ent.mode = MODE_IDLE;
                end
                ACT_UPDATE: begin
                    retire      = sounding && (r_now >= ent.stop);
                    wr_ent.mode = MODE_IDLE;
                end
                default: ;
            endcase
            if (retire) begin
                wr_en = 1'b1;
            end
        end else if (r_state == S_WRITE) begin
            wr_ent  = new_ent;
            wr_addr = r_fnd_idle ? r_idle_slot : r_vic;
            wr_en   = r_fnd_idle || (r_steal_en && r_have_vic);
        end
        sound_cnt = CW'(NUM_VOICES) - r_idle_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_vld      <= '0;
            r_idle_cnt <= CW'(NUM_VOICES);
            r_steal_en <= 1'b1;
            r_policy   <= POL_PRIORITY;
            r_m_valid  <= 1'b0;
            r_dv       <= 1'b0;
            r_ent_vld  <= 1'b0;
            r_granted  <= 1'b0;
            r_stolen   <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_addr == REG_STEAL_ENABLE) r_steal_en <= i_cfg_data[0];
                else if (i_cfg_addr == REG_STEAL_POLICY) r_policy <= i_cfg_data[1:0];
            end
            if (r_m_valid && i_m_axis_tready && r_state != S_FIN) begin
                r_m_valid <= 1'b0;
            end
            if (wr_en) begin
                r_vld[wr_addr] <= 1'b1;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_act      <= i_s_axis_tuser;
                        r_pitch    <= i_s_axis_tdata[6:0];
                        r_vel      <= i_s_axis_tdata[13:7];
                        r_prio     <= i_s_axis_tdata[15:14];
                        r_role     <= i_s_axis_tdata[19:16];
                        r_now      <= now_in;
                        r_stop_new <= ovf ? '1 : sum[TB-1:0];
                        r_iss_done <= 1'b0;
                        r_dv       <= 1'b0;
                        r_fnd_idle <= 1'b0;
                        r_have_vic <= 1'b0;
                        r_granted  <= 1'b0;
                        r_stolen   <= 1'b0;
                        r_slot_out <= '0;
                        case (i_s_axis_tuser)
                            ACT_ALLOC, ACT_STOP_ALL, ACT_STOP_ROLE, ACT_UPDATE: begin
                                r_cnt   <= '0;
                                r_last  <= AW'(NUM_VOICES - 1);
                                r_state <= S_SCAN;
                            end
                            ACT_RELEASE: begin
                                r_cnt   <= AW'(i_s_axis_tdata[104:100]);
                                r_last  <= AW'(i_s_axis_tdata[104:100]);
                                r_state <= (target9 >= 9'(NUM_VOICES)) ? S_FIN : S_SCAN;
                            end
                            default: begin
                                r_cnt   <= '0;
                                r_last  <= AW'(NUM_VOICES - 1);
                                r_state <= S_FIN;
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    r_dv <= !r_iss_done;
                    if (!r_iss_done) begin
                        r_didx    <= r_cnt;
                        r_ent_vld <= r_vld[r_cnt];
                        if (r_cnt == r_last) r_iss_done <= 1'b1;
                        else r_cnt <= r_cnt + 1'b1;
                    end
                    if (r_dv) begin
                        if (retire) r_idle_cnt <= r_idle_cnt + 1'b1;
                        if (r_act == ACT_ALLOC) begin
                            if (ent.mode == MODE_IDLE && !r_fnd_idle) begin
                                r_fnd_idle  <= 1'b1;
                                r_idle_slot <= r_didx;
                            end
                            // first strictly better candidate wins ties
                            if (sounding && ent.role != r_role && (!r_have_vic || better)) begin
                                r_have_vic  <= 1'b1;
                                r_vic       <= r_didx;
                                r_vic_prio  <= ent.prio;
                                r_vic_vel   <= ent.vel;
                                r_vic_start <= ent.start;
                            end
                        end
                        if (r_didx == r_last) begin
                            r_state <= (r_act == ACT_ALLOC) ? S_WRITE : S_FIN;
                        end
                    end
                end
                S_WRITE: begin
                    if (wr_en) begin
                        r_granted  <= 1'b1;
                        r_stolen   <= !r_fnd_idle;
                        r_slot_out <= 5'(wr_addr);
                        if (r_fnd_idle) r_idle_cnt <= r_idle_cnt - 1'b1;
                    end
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (!r_m_valid || i_m_axis_tready) begin
                        r_m_valid <= 1'b1;
                        r_m_data  <= {5'b0, 6'(r_idle_cnt), 6'(sound_cnt),
                                      r_stolen, r_granted, r_slot_out};
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_idle_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idle_cnt <= CW'(NUM_VOICES))
        else $error("idle count above voice count");
    a_stolen_granted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stolen |-> r_granted)
        else $error("stolen without grant");
    a_write_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> (r_state == S_SCAN || r_state == S_WRITE))
        else $error("table write outside scan or write");
    a_write_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WRITE) |=> (r_state == S_FIN))
        else $error("allocate write not followed by result");
endmodule
`default_nettype wire

// ===== bench/tb_poly_voice_allocator_top.sv =====
`timescale 1ns / 1ps
module tb_poly_voice_allocator_top;
    import pva_pkg::*;

    localparam int NV          = 32;
    localparam int WATCH_LIMIT = 20000;
    localparam int SETTLE      = NV + 8;
    localparam logic [47:0] TMAX = 48'hFFFF_FFFF_FFFF;
    // codes the block takes but does nothing with; policy 3 falls back to oldest first
    localparam logic [2:0] ACT_SPARE_5 = 3'd5;
    localparam logic [2:0] ACT_SPARE_6 = 3'd6;
    localparam logic [2:0] ACT_SPARE_7 = 3'd7;
    localparam logic [1:0] POL_FURTHEST = 2'd3;

    typedef struct packed {
        logic [5:0] free_cnt;
        logic [5:0] sound_cnt;
        logic       stolen;
        logic       granted;
        logic [4:0] slot;
    } t_slot_report;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_s_axis_tvalid;
    logic         o_s_axis_tready;
    logic [111:0] i_s_axis_tdata;
    logic [2:0]   i_s_axis_tuser;
    logic         o_m_axis_tvalid;
    logic         i_m_axis_tready;
    logic [23:0]  o_m_axis_tdata;
    logic         i_cfg_valid;
    logic         o_cfg_ready;
    logic [7:0]   i_cfg_addr;
    logic [7:0]   i_cfg_data;

    poly_voice_allocator_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_data      (i_cfg_data)
    );

    // voice table as the block should hold it
    logic [1:0]  tbl_mode  [NV];
    logic [1:0]  tbl_prio  [NV];
    logic [6:0]  tbl_pitch [NV];
    logic [6:0]  tbl_vel   [NV];
    logic [3:0]  tbl_role  [NV];
    logic [47:0] tbl_start [NV];
    logic [47:0] tbl_stop  [NV];
    logic        steal_en;
    logic [1:0]  steal_pol;

    t_slot_report pending_reports[$];
    int  mismatches;
    int  reports_seen;
    int  notes_sent;
    int  steals_seen;
    int  idle_cycles;
    int  hold_req;
    int  rx_stall_left;
    bit  rx_quiet;
    bit  tx_quiet;
    logic [47:0] song_time;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic bit voice_sounding(int i);
        return tbl_mode[i] == MODE_ACTIVE || tbl_mode[i] == MODE_RELEASING;
    endfunction

    function automatic int choose_victim(logic [3:0] role);
        int  best;
        bit  better;
        best = -1;
        for (int i = 0; i < NV; i++) begin
            if (!voice_sounding(i) || tbl_role[i] == role) continue;
            if (best < 0) better = 1'b1;
            else if (steal_pol == POL_PRIORITY) better = tbl_prio[i] > tbl_prio[best];
            else if (steal_pol == POL_QUIETEST) better = tbl_vel[i] < tbl_vel[best];
            else better = tbl_start[i] < tbl_start[best];
            if (better) best = i;
        end
        return best;
    endfunction

    function automatic t_slot_report apply_voice_event(logic [2:0] act, logic [111:0] d);
        t_slot_report r;
        logic [6:0]  pitch;
        logic [6:0]  vel;
        logic [1:0]  prio;
        logic [3:0]  role;
        logic [47:0] now;
        logic [31:0] dur;
        logic [4:0]  tgt;
        int          slot;
        pitch = d[6:0];
        vel   = d[13:7];
        prio  = d[15:14];
        role  = d[19:16];
        now   = d[67:20];
        dur   = d[99:68];
        tgt   = d[104:100];
        r     = '0;
        case (act)
            ACT_ALLOC: begin
                slot = -1;
                for (int i = 0; i < NV; i++)
                    if (slot < 0 && tbl_mode[i] == MODE_IDLE) slot = i;
                if (slot < 0 && steal_en) begin
                    slot = choose_victim(role);
                    if (slot >= 0) r.stolen = 1'b1;
                end
                if (slot >= 0) begin
                    tbl_mode[slot]  = MODE_ACTIVE;
                    tbl_prio[slot]  = prio;
                    tbl_pitch[slot] = pitch;
                    tbl_vel[slot]   = vel;
                    tbl_role[slot]  = role;
                    tbl_start[slot] = now;
                    // stop time saturates at the top of the time range
                    tbl_stop[slot]  = ({16'd0, dur} > TMAX - now) ? TMAX : now + dur;
                    r.slot    = slot[4:0];
                    r.granted = 1'b1;
                end
            end
            ACT_RELEASE: begin
                if (tbl_mode[tgt] == MODE_ACTIVE) begin
                    tbl_mode[tgt] = MODE_RELEASING;
                    tbl_stop[tgt] = now;
                end
            end
            ACT_STOP_ALL: begin
                for (int i = 0; i < NV; i++)
                    if (voice_sounding(i)) begin
                        tbl_mode[i]  = MODE_IDLE;
                        tbl_pitch[i] = '0;
                        tbl_vel[i]   = '0;
                        tbl_start[i] = '0;
                        tbl_stop[i]  = '0;
                    end
            end
            ACT_STOP_ROLE: begin
                for (int i = 0; i < NV; i++)
                    if (voice_sounding(i) && tbl_role[i] == role) tbl_mode[i] = MODE_IDLE;
            end
            ACT_UPDATE: begin
                for (int i = 0; i < NV; i++)
                    if (voice_sounding(i) && now >= tbl_stop[i]) tbl_mode[i] = MODE_IDLE;
            end
            default: ;
        endcase
        for (int i = 0; i < NV; i++) begin
            if (tbl_mode[i] == MODE_IDLE) r.free_cnt++;
            else if (voice_sounding(i)) r.sound_cnt++;
        end
        return r;
    endfunction

    function automatic int rand_gap();
        if (tx_quiet || $urandom_range(0, 2) != 0) return 0;
        if ($urandom_range(0, 15) == 0) return $urandom_range(20, 60);
        return $urandom_range(1, 4);
    endfunction

    // one note event over the input stream, predicted once accepted
    task automatic send_event(logic [2:0] act, logic [6:0] pitch, logic [6:0] vel,
                              logic [1:0] prio, logic [3:0] role, logic [47:0] tstamp,
                              logic [31:0] dur, logic [4:0] tgt);
        int gap;
        logic [111:0] d;
        t_slot_report exp_r;
        gap = rand_gap();
        d   = {7'd0, tgt, dur, tstamp, role, prio, vel, pitch};
        if (gap > 0) begin
            @(negedge i_clk);
            i_s_axis_tvalid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tdata  = d;
        i_s_axis_tuser  = act;
        do @(posedge i_clk); while (!o_s_axis_tready);
        exp_r = apply_voice_event(act, d);
        pending_reports = {pending_reports, exp_r};
        notes_sent++;
    endtask

    task automatic drain_reports();
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b0;
        while (pending_reports.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [7:0] addr, logic [7:0] val);
        drain_reports();
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_addr  = addr;
        i_cfg_data  = val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (addr == REG_STEAL_ENABLE) steal_en = val[0];
        else if (addr == REG_STEAL_POLICY) steal_pol = val[1:0];
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // results side: check and throttle
    always @(posedge i_clk) begin
        t_slot_report got;
        t_slot_report want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got = o_m_axis_tdata[18:0];
            reports_seen++;
            if (pending_reports.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", got);
            end else begin
                want = pending_reports.pop_front();
                if (want.granted && want.stolen) steals_seen++;
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("result %0d: exp slot=%0d grant=%0b stolen=%0b snd=%0d free=%0d",
                                 reports_seen, want.slot, want.granted, want.stolen,
                                 want.sound_cnt, want.free_cnt);
                        $display("    got slot=%0d grant=%0b stolen=%0b snd=%0d free=%0d",
                                 got.slot, got.granted, got.stolen, got.sound_cnt,
                                 got.free_cnt);
                    end
                end
            end
        end
    end

    always @(negedge i_clk) begin
        if (hold_req > 0) begin
            rx_stall_left = hold_req;
            hold_req = 0;
        end
        if (rx_stall_left > 0) begin
            i_m_axis_tready = 1'b0;
            rx_stall_left--;
        end else begin
            i_m_axis_tready = 1'b1;
            if (!rx_quiet && $urandom_range(0, 3) == 0)
                rx_stall_left = ($urandom_range(0, 12) == 0) ? $urandom_range(20, 70)
                                                             : $urandom_range(1, 3);
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)
            || (i_cfg_valid && o_cfg_ready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCH_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", WATCH_LIMIT);
            $display("tb_poly_voice_allocator_top NOT OK");
            $finish;
        end
    end

    task automatic test_directed();
        send_event(ACT_ALLOC, 7'd127, 7'd0, 2'd0, 4'd15, TMAX, 32'hFFFF_FFFF, 5'd31);
        send_event(ACT_ALLOC, 7'd0, 7'd127, 2'd3, 4'd0, 48'd0, 32'd0, 5'd0);
        send_event(ACT_ALLOC, 7'd64, 7'd1, 2'd1, 4'd5, 48'd100, 32'd50, 5'd0);
        send_event(ACT_ALLOC, 7'd1, 7'd90, 2'd2, 4'd5, TMAX - 48'd10, 32'd10, 5'd0);
        send_event(ACT_RELEASE, 7'd0, 7'd0, 2'd0, 4'd0, 48'd120, 32'd0, 5'd2);
        send_event(ACT_RELEASE, 7'd0, 7'd0, 2'd0, 4'd0, 48'd130, 32'd0, 5'd2);
        send_event(ACT_RELEASE, 7'd0, 7'd0, 2'd0, 4'd0, 48'd0, 32'd0, 5'd31);
        send_event(ACT_UPDATE, 7'd0, 7'd0, 2'd0, 4'd0, 48'd119, 32'd0, 5'd0);
        send_event(ACT_UPDATE, 7'd0, 7'd0, 2'd0, 4'd0, 48'd120, 32'd0, 5'd0);
        send_event(ACT_STOP_ROLE, 7'd0, 7'd0, 2'd0, 4'd5, 48'd0, 32'd0, 5'd0);
        send_event(ACT_SPARE_5, 7'd127, 7'd127, 2'd3, 4'd15, TMAX, 32'hFFFF_FFFF, 5'd31);
        send_event(ACT_SPARE_6, 7'd0, 7'd0, 2'd0, 4'd0, 48'd0, 32'd0, 5'd0);
        send_event(ACT_SPARE_7, 7'd5, 7'd5, 2'd1, 4'd1, 48'd5, 32'd5, 5'd5);
        send_event(ACT_STOP_ALL, 7'd0, 7'd0, 2'd0, 4'd0, 48'd0, 32'd0, 5'd0);
        send_event(ACT_UPDATE, 7'd0, 7'd0, 2'd0, 4'd0, TMAX, 32'd0, 5'd0);
        send_event(ACT_RELEASE, 7'd0, 7'd0, 2'd0, 4'd0, 48'd0, 32'd0, 5'd0);
    endtask

    // mostly note traffic that fills the table, so stealing comes up often
    task automatic test_random_traffic(int count, int role_span);
        int          pick;
        logic [2:0]  act;
        logic [47:0] ts;
        logic [31:0] dur;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) act = ACT_ALLOC;
            else if (pick < 72) act = ACT_RELEASE;
            else if (pick < 84) act = ACT_UPDATE;
            else if (pick < 92) act = ACT_STOP_ROLE;
            else if (pick < 95) act = ACT_STOP_ALL;
            else act = 3'($urandom_range(5, 7));
            song_time = song_time + 48'($urandom_range(0, 40));
            ts  = song_time;
            dur = 32'($urandom_range(0, 400));
            if ($urandom_range(0, 19) == 0) ts = 48'({$urandom(), $urandom()});
            if ($urandom_range(0, 19) == 0) dur = $urandom();
            send_event(act, 7'($urandom), 7'($urandom), 2'($urandom),
                       4'($urandom_range(0, role_span)), ts, dur, 5'($urandom));
        end
    endtask

    task automatic test_backpressure();
        // the receiver holds off while notes keep being offered
        hold_req = 400;
        test_random_traffic(40, 3);
        drain_reports();
        test_random_traffic(40, 15);
    endtask

    task automatic test_policies();
        logic [1:0] pols[4];
        pols = '{POL_OLDEST, POL_PRIORITY, POL_QUIETEST, POL_FURTHEST};
        for (int p = 0; p < 4; p++) begin
            write_reg(REG_STEAL_POLICY, {6'd0, pols[p]});
            tx_quiet = (p == 1);
            rx_quiet = (p == 2);
            test_random_traffic(200, (p == 3) ? 1 : 3);
        end
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
        write_reg(REG_STEAL_ENABLE, 8'd0);
        test_random_traffic(250, 3);
        write_reg(REG_STEAL_ENABLE, 8'd1);
        write_reg(REG_STEAL_POLICY, {6'd0, POL_PRIORITY});
        test_random_traffic(200, 15);
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tuser  = ACT_ALLOC;
        i_m_axis_tready = 1'b0;
        i_cfg_valid     = 1'b0;
        i_cfg_addr      = REG_STEAL_ENABLE;
        i_cfg_data      = '0;
        mismatches = 0;
        reports_seen = 0;
        notes_sent = 0;
        steals_seen = 0;
        hold_req = 0;
        rx_stall_left = 0;
        rx_quiet = 1'b0;
        tx_quiet = 1'b0;
        song_time = '0;
        for (int i = 0; i < NV; i++) begin
            tbl_mode[i]  = MODE_IDLE;
            tbl_prio[i]  = PRIO_RESET;
            tbl_pitch[i] = '0;
            tbl_vel[i]   = '0;
            tbl_role[i]  = '0;
            tbl_start[i] = '0;
            tbl_stop[i]  = '0;
        end
        steal_en  = 1'b1;
        steal_pol = POL_PRIORITY;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_random_traffic(300, 3);
        test_backpressure();
        test_policies();
        drain_reports();

        $display("sent %0d note events, checked %0d results, %0d granted by stealing",
                 notes_sent, reports_seen, steals_seen);
        $display("covered all actions, every steal policy, stealing off, and long stalls");
        if (mismatches == 0 && pending_reports.size() == 0) begin
            $display("tb_poly_voice_allocator_top OK");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("tb_poly_voice_allocator_top NOT OK");
        end
        $finish;
    end
endmodule
